// ----- rtl/phpc_pkg.sv -----
// Package for the packet header parse and classify unit.
// Holds protocol constants, class codes and shared types; no dependencies.
`default_nettype none
package phpc_pkg;
  localparam int MaxFrame = 16384;
  localparam int OffW = 15;

  localparam logic [15:0] EthVlan = 16'h8100;
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthIpv6 = 16'h86DD;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoSctp = 8'd132;

  localparam logic [2:0] ClsDrop = 3'd0;
  localparam logic [2:0] ClsGtpc = 3'd1;
  localparam logic [2:0] ClsGtpu = 3'd2;
  localparam logic [2:0] ClsPfcp = 3'd3;
  localparam logic [2:0] ClsDiam = 3'd4;
  localparam logic [2:0] ClsS1ap = 3'd5;
  localparam logic [2:0] ClsOther = 3'd6;

  localparam logic [3:0] RoleS11 = 4'd1;
  localparam logic [3:0] RoleS5 = 4'd2;
  localparam logic [3:0] RoleS8 = 4'd3;
  localparam logic [3:0] RoleS1u = 4'd4;
  localparam logic [3:0] RoleN3 = 4'd5;
  localparam logic [3:0] RoleN4 = 4'd6;
  localparam logic [3:0] RoleDiam = 4'd7;
  localparam logic [3:0] RoleS1mme = 4'd8;

  localparam logic [2:0] RegGtpc = 3'd0;
  localparam logic [2:0] RegGtpu = 3'd1;
  localparam logic [2:0] RegPfcp = 3'd2;
  localparam logic [2:0] RegDiam = 3'd3;
  localparam logic [2:0] RegS1ap = 3'd4;
  localparam logic [2:0] RegPpid = 3'd5;

  typedef struct packed {
    logic [15:0] gtpc_port;
    logic [15:0] gtpu_port;
    logic [15:0] pfcp_port;
    logic [15:0] diameter_port;
    logic [15:0] s1ap_port;
    logic [31:0] s1ap_ppid;
  } cfg_t;

  // Frame summary handed from the parser to the finishing stage.
  typedef struct packed {
    logic        vlan;
    logic [15:0] ether_kind;
    logic [7:0]  ip_header_len;
    logic [OffW-1:0] l4_start;
    logic [7:0]  l4_proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] ports;
    logic [7:0]  tcp_doff;
    logic        fragment;
    logic        found;
    logic [OffW-1:0] found_off;
    logic [OffW:0] found_len;
    logic        walk_error;
    logic [OffW-1:0] flen;
    logic [3:0]  role;
  } frame_t;

  // Listed from the highest bits down, so protocol_class lands in the lowest bits.
  typedef struct packed {
    logic [14:0] frame_length;
    logic [63:0] dest_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] source_addr_high;
    logic [14:0] payload_length;
    logic [13:0] payload_offset;
    logic [15:0] destination_port;
    logic [15:0] source_port;
    logic [7:0]  l4_protocol;
    logic        ip_is_v6;
    logic [2:0]  protocol_class;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/phpc_cfg_regs.sv -----
// Configuration register bank of the packet header parse and classify unit.
// Depends on phpc_pkg.
`default_nettype none
module phpc_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data,
  output phpc_pkg::cfg_t   cfg
);
  phpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gtpc_port     <= 16'd2123;
      cfg_r.gtpu_port     <= 16'd2152;
      cfg_r.pfcp_port     <= 16'd8805;
      cfg_r.diameter_port <= 16'd3868;
      cfg_r.s1ap_port     <= 16'd36412;
      cfg_r.s1ap_ppid     <= 32'd18;
    end else if (wr_en) begin
      case (wr_index)
        phpc_pkg::RegGtpc: cfg_r.gtpc_port <= wr_data[15:0];
        phpc_pkg::RegGtpu: cfg_r.gtpu_port <= wr_data[15:0];
        phpc_pkg::RegPfcp: cfg_r.pfcp_port <= wr_data[15:0];
        phpc_pkg::RegDiam: cfg_r.diameter_port <= wr_data[15:0];
        phpc_pkg::RegS1ap: cfg_r.s1ap_port <= wr_data[15:0];
        phpc_pkg::RegPpid: cfg_r.s1ap_ppid <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ----- rtl/phpc_parser.sv -----
// Byte-at-a-time header parser: tracks offsets, captures fields and walks
// SCTP chunks. Emits a frame summary on the last byte. Depends on phpc_pkg.
`default_nettype none
module phpc_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        byte_en,
  input  wire logic [7:0]  b,
  input  wire logic        last,
  input  wire logic [3:0]  role,
  input  wire logic [31:0] ppid_cfg,
  output phpc_pkg::frame_t summary,
  output logic             done
);
  localparam int W = phpc_pkg::OffW;

  logic [W:0]  off_r;
  logic        vlan_r;
  logic [15:0] kind_r;
  logic [7:0]  ihl_r;
  logic [W-1:0] l4s_r;
  logic [7:0]  proto_r;
  logic [63:0] sh_r, sl_r, dh_r, dl_r;
  logic [31:0] ports_r;
  logic [7:0]  doff_r;
  logic        frag_r;
  logic [W:0]  cs_r;
  logic [31:0] ch_r;
  logic [31:0] pp_r;
  logic        fv_r;
  logic [W-1:0] fo_r;
  logic [W:0]  fl_r;
  logic        we_r;

  logic [W:0]  off_nxt;
  logic        vlan_nxt;
  logic [15:0] kind_nxt;
  logic [7:0]  ihl_nxt;
  logic [W-1:0] l4s_nxt;
  logic [7:0]  proto_nxt;
  logic [63:0] sh_nxt, sl_nxt, dh_nxt, dl_nxt;
  logic [31:0] ports_nxt;
  logic [7:0]  doff_nxt;
  logic        frag_nxt;
  logic [W:0]  cs_nxt;
  logic [31:0] ch_nxt;
  logic [31:0] pp_nxt;
  logic        fv_nxt;
  logic [W-1:0] fo_nxt;
  logic [W:0]  fl_nxt;
  logic        we_nxt;

  logic [W:0]  base;
  logic [W:0]  r;
  logic [W:0]  s;
  logic [W:0]  c;
  logic [15:0] clen;
  logic [15:0] clen_new;
  logic [31:0] ch_sh;
  logic [31:0] pp_sh;
  logic [31:0] pp_swap;
  logic        is_v4, is_v6, l4_go;
  logic [W:0]  o;

  // Next chunk start: the length padded to four bytes. A start beyond the
  // largest frame saturates, since no later byte can reach it.
  function automatic logic [W:0] chunk_next(input logic [W:0] cs, input logic [15:0] l);
    logic [17:0] t;
    t = {2'b0, cs} + {2'b0, l} + {16'd0, 2'(-l[1:0])};
    return (t > 18'(phpc_pkg::MaxFrame)) ? '1 : t[W:0];
  endfunction

  always_comb begin
    off_nxt = off_r; vlan_nxt = vlan_r; kind_nxt = kind_r; ihl_nxt = ihl_r;
    l4s_nxt = l4s_r; proto_nxt = proto_r; sh_nxt = sh_r; sl_nxt = sl_r;
    dh_nxt = dh_r; dl_nxt = dl_r; ports_nxt = ports_r; doff_nxt = doff_r;
    frag_nxt = frag_r; cs_nxt = cs_r; ch_nxt = ch_r; pp_nxt = pp_r;
    fv_nxt = fv_r; fo_nxt = fo_r; fl_nxt = fl_r; we_nxt = we_r;
    o = off_r;
    base = vlan_r ? (W+1)'(18) : (W+1)'(14);
    r = o - base;
    is_v4 = (kind_r == phpc_pkg::EthIpv4);
    is_v6 = (kind_r == phpc_pkg::EthIpv6);
    s = r - {{(W-7){1'b0}}, ihl_r};
    c = s - cs_r;
    clen = ch_r[15:0];
    ch_sh = {ch_r[23:0], b};
    clen_new = ch_sh[15:0];
    pp_sh = {pp_r[23:0], b};
    pp_swap = {pp_sh[7:0], pp_sh[15:8], pp_sh[23:16], pp_sh[31:24]};
    l4_go = 1'b0;

    if (o < (W+1)'(phpc_pkg::MaxFrame)) begin
      if (o == (W+1)'(12)) begin
        kind_nxt = {b, 8'd0};
      end else if (o == (W+1)'(13)) begin
        kind_nxt = {kind_r[15:8], b};
        vlan_nxt = ({kind_r[15:8], b} == phpc_pkg::EthVlan);
      end else if (o < (W+1)'(14)) begin
      end else if (vlan_r && o < (W+1)'(18)) begin
        if (o == (W+1)'(16)) kind_nxt = {b, 8'd0};
        if (o == (W+1)'(17)) kind_nxt = {kind_r[15:8], b};
      end else if (is_v4) begin
        if (r == 0) begin
          ihl_nxt = {2'b0, b[3:0], 2'b0};
          l4s_nxt = W'(base + (W+1)'({b[3:0], 2'b0}));
        end else if (r == 6) frag_nxt = (b[4:0] != 0);
        else if (r == 7) frag_nxt = frag_r || (b != 0);
        else if (r == 9) proto_nxt = b;
        else if (r >= 12 && r < 16) sl_nxt = {sl_r[55:0], b};
        else if (r >= 16 && r < 20) dl_nxt = {dl_r[55:0], b};
        // The header length used below is the one in force before this byte.
        l4_go = (r != 0) && (ihl_r >= 8'd20);
      end else if (is_v6) begin
        if (r == 0) begin
          ihl_nxt = 8'd40;
          l4s_nxt = W'(base + (W+1)'(40));
        end else if (r == 6) proto_nxt = b;
        else if (r >= 8 && r < 16) sh_nxt = {sh_r[55:0], b};
        else if (r >= 16 && r < 24) sl_nxt = {sl_r[55:0], b};
        else if (r >= 24 && r < 32) dh_nxt = {dh_r[55:0], b};
        else if (r >= 32 && r < 40) dl_nxt = {dl_r[55:0], b};
        l4_go = (r != 0);
      end
      if (l4_go && r >= {{(W-7){1'b0}}, ihl_r}) begin
        if (s < 4) ports_nxt = {ports_r[23:0], b};
        if (s == 12) doff_nxt = {2'b0, b[7:4], 2'b0};
        if (proto_r == phpc_pkg::ProtoSctp && s >= 12 &&
            !we_r && !fv_r && s >= cs_r) begin
          if (c < 4) begin
            ch_nxt = ch_sh;
            if (c == 3) begin
              if (clen_new < 16'd4) we_nxt = 1'b1;
              else if (!(ch_sh[31:24] == 8'd0 && ch_sh[17:16] == 2'b11 &&
                         clen_new >= 16'd17))
                cs_nxt = chunk_next(cs_r, clen_new);
            end
          end else if (c >= 12 && c < 16) begin
            pp_nxt = pp_sh;
            if (c == 15) begin
              if (pp_sh == ppid_cfg || pp_swap == ppid_cfg) begin
                fv_nxt = 1'b1;
                fo_nxt = W'(cs_r + (W+1)'(16));
                fl_nxt = (W+1)'(clen - 16'd16);
              end else begin
                cs_nxt = chunk_next(cs_r, clen);
              end
            end
          end
        end
      end
    end
    if (o <= (W+1)'(phpc_pkg::MaxFrame)) off_nxt = o + (W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last)) begin
      off_r <= '0; vlan_r <= 1'b0; kind_r <= '0; ihl_r <= '0; l4s_r <= '0;
      proto_r <= '0; sh_r <= '0; sl_r <= '0; dh_r <= '0; dl_r <= '0;
      ports_r <= '0; doff_r <= '0; frag_r <= 1'b0; cs_r <= (W+1)'(12);
      ch_r <= '0; pp_r <= '0; fv_r <= 1'b0; fo_r <= '0; fl_r <= '0;
      we_r <= 1'b0;
    end else if (byte_en) begin
      off_r <= off_nxt; vlan_r <= vlan_nxt; kind_r <= kind_nxt; ihl_r <= ihl_nxt;
      l4s_r <= l4s_nxt; proto_r <= proto_nxt; sh_r <= sh_nxt; sl_r <= sl_nxt;
      dh_r <= dh_nxt; dl_r <= dl_nxt; ports_r <= ports_nxt; doff_r <= doff_nxt;
      frag_r <= frag_nxt; cs_r <= cs_nxt; ch_r <= ch_nxt; pp_r <= pp_nxt;
      fv_r <= fv_nxt; fo_r <= fo_nxt; fl_r <= fl_nxt; we_r <= we_nxt;
    end
  end

  // Frame summary registered on the last byte.
  phpc_pkg::frame_t sum_r;
  logic             done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= byte_en && last;
    if (byte_en && last) begin
      sum_r.vlan <= vlan_nxt; sum_r.ether_kind <= kind_nxt;
      sum_r.ip_header_len <= ihl_nxt; sum_r.l4_start <= l4s_nxt;
      sum_r.l4_proto <= proto_nxt; sum_r.src_hi <= sh_nxt; sum_r.src_lo <= sl_nxt;
      sum_r.dst_hi <= dh_nxt; sum_r.dst_lo <= dl_nxt; sum_r.ports <= ports_nxt;
      sum_r.tcp_doff <= doff_nxt; sum_r.fragment <= frag_nxt; sum_r.found <= fv_nxt;
      sum_r.found_off <= fo_nxt; sum_r.found_len <= fl_nxt;
      sum_r.walk_error <= we_nxt;
      // A frame longer than the maximum saturates the counter at MaxFrame + 1.
      sum_r.flen <= (off_nxt > (W+1)'(phpc_pkg::MaxFrame)) ? '1 : off_nxt[W-1:0];
      sum_r.role <= role;
    end
  end

  assign summary = sum_r;
  assign done = done_r;
endmodule
`default_nettype wire

// ----- rtl/phpc_finish.sv -----
// Length checks and protocol classification of a parsed frame summary.
// Pure combinational logic; depends on phpc_pkg.
`default_nettype none
module phpc_finish (
  input  phpc_pkg::frame_t  f,
  input  phpc_pkg::cfg_t    cfg,
  output phpc_pkg::result_t res
);
  localparam int W = phpc_pkg::OffW;
  logic [W:0] flen, base, len3, l4len, poff, plen;
  logic       ok, too_long;
  logic [15:0] sp, dp;
  logic [2:0] cls;
  logic [W+1:0] fend;

  always_comb begin
    too_long = (f.flen == '1);
    flen = {1'b0, f.flen};
    base = f.vlan ? (W+1)'(18) : (W+1)'(14);
    len3 = flen - base;
    l4len = len3 - {{(W-7){1'b0}}, f.ip_header_len};
    fend = {2'b0, f.found_off} + {1'b0, f.found_len};
    sp = f.ports[31:16];
    dp = f.ports[15:0];
    ok = 1'b1;
    poff = '0;
    plen = '0;
    if (too_long || flen < base) ok = 1'b0;
    if (f.ether_kind == phpc_pkg::EthIpv4) begin
      if (len3 < 20 || f.ip_header_len < 8'd20 ||
          len3 < {{(W-7){1'b0}}, f.ip_header_len} || f.fragment) ok = 1'b0;
    end else if (f.ether_kind == phpc_pkg::EthIpv6) begin
      if (len3 < 40) ok = 1'b0;
    end else begin
      ok = 1'b0;
    end
    if (l4len < 4) ok = 1'b0;
    if (f.l4_proto == phpc_pkg::ProtoUdp && l4len >= 8) begin
      poff = (W+1)'(8); plen = l4len - (W+1)'(8);
    end else if (f.l4_proto == phpc_pkg::ProtoTcp && l4len >= 20) begin
      if (f.tcp_doff < 8'd20 || l4len < {{(W-7){1'b0}}, f.tcp_doff}) ok = 1'b0;
      poff = {{(W-7){1'b0}}, f.tcp_doff};
      plen = l4len - {{(W-7){1'b0}}, f.tcp_doff};
    end else if (f.l4_proto == phpc_pkg::ProtoSctp) begin
      if (f.walk_error || !f.found || fend > {1'b0, l4len}) ok = 1'b0;
      poff = {1'b0, f.found_off}; plen = f.found_len;
    end else begin
      ok = 1'b0;
    end
    if (plen == 0) ok = 1'b0;
    poff = poff + {1'b0, f.l4_start};

    if (sp == cfg.gtpc_port || dp == cfg.gtpc_port || f.role == phpc_pkg::RoleS11 ||
        f.role == phpc_pkg::RoleS5 || f.role == phpc_pkg::RoleS8)
      cls = phpc_pkg::ClsGtpc;
    else if (sp == cfg.gtpu_port || dp == cfg.gtpu_port || f.role == phpc_pkg::RoleS1u ||
             f.role == phpc_pkg::RoleN3)
      cls = phpc_pkg::ClsGtpu;
    else if (sp == cfg.pfcp_port || dp == cfg.pfcp_port || f.role == phpc_pkg::RoleN4)
      cls = phpc_pkg::ClsPfcp;
    else if (sp == cfg.diameter_port || dp == cfg.diameter_port ||
             f.role == phpc_pkg::RoleDiam)
      cls = phpc_pkg::ClsDiam;
    else if ((sp == cfg.s1ap_port || dp == cfg.s1ap_port || f.role == phpc_pkg::RoleS1mme)
             && f.l4_proto == phpc_pkg::ProtoSctp)
      cls = phpc_pkg::ClsS1ap;
    else
      cls = phpc_pkg::ClsOther;

    res = '0;
    if (ok) begin
      res.protocol_class = cls;
      res.ip_is_v6 = (f.ether_kind == phpc_pkg::EthIpv6);
      res.l4_protocol = f.l4_proto;
      res.source_port = sp;
      res.destination_port = dp;
      res.payload_offset = poff[13:0];
      res.payload_length = plen[14:0];
      res.source_addr_high = f.src_hi;
      res.source_addr_low = f.src_lo;
      res.dest_addr_high = f.dst_hi;
      res.dest_addr_low = f.dst_lo;
      res.frame_length = flen[14:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/packet_header_parse_classify_unit.sv -----
// Top level of the packet header parse and classify unit.
// Instantiates phpc_cfg_regs, phpc_parser and phpc_finish; uses phpc_pkg.
`default_nettype none
// The unit takes a captured Ethernet frame one byte per item and returns one
// result item per frame, after the byte marked tlast. Bytes are accepted every
// cycle but for the stall below; the parser updates its offset-driven state in
// the cycle a byte is accepted, the frame summary is registered on the last
// byte, and the next cycle runs the length checks and classification into a
// two-entry output buffer. Input is held off only on a last byte, while the
// output buffer would be full, so throughput is one byte per cycle while the
// result side keeps up. Dropped frames still yield a result, with class zero and
// all fields zero. Configuration writes are taken at any time but must only be
// made while no frame is in progress.
module packet_header_parse_classify_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] frame_byte
  input  wire logic         in_tlast,   // last_byte
  input  wire logic [3:0]   in_tuser,   // [3:0] capture_role
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [2:0] protocol_class, [3] ip_is_v6, [11:4] l4_protocol, [27:12] source_port,
  // [43:28] destination_port, [57:44] payload_offset, [72:58] payload_length,
  // [136:73] source_addr_high, [200:137] source_addr_low,
  // [264:201] dest_addr_high, [328:265] dest_addr_low, [343:329] frame_length,
  // [351:344] zero
  output logic [351:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  phpc_pkg::cfg_t    cfg;
  phpc_pkg::frame_t  summary;
  phpc_pkg::result_t res;
  logic              done;
  logic              in_acc;

  // Two-entry result buffer; a frame in flight needs at most one free slot.
  phpc_pkg::result_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       pop;

  assign cfg_ready = 1'b1;
  assign in_acc = in_tvalid && in_tready;
  // Stall on a last byte unless a slot remains once in-flight results land.
  assign in_tready = !in_tlast || (cnt_r + {1'b0, done}) < 2'd2 || pop;

  phpc_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  phpc_parser u_parse (
    .clk(clk), .rst_n(rst_n), .byte_en(in_acc), .b(in_tdata), .last(in_tlast),
    .role(in_tuser), .ppid_cfg(cfg.s1ap_ppid), .summary(summary), .done(done)
  );

  phpc_finish u_fin (.f(summary), .cfg(cfg), .res(res));

  assign pop = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = {8'd0, buf_r[rd_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      if (done) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, done} - {1'b0, pop};
    end
    if (done) buf_r[wr_r] <= res;
  end
endmodule
`default_nettype wire
